### sv/gbs_pkg.sv
`default_nettype none

package gbs_pkg;

    // Field widths fixed by the word format
    localparam int BOX_BITS   = 16;
    localparam int INDEX_BITS = 16;
    localparam int THR_BITS   = 16;

    // Threshold after reset: 0.5 in Q0.16
    localparam logic [THR_BITS-1:0] IOU_THR_RESET = 16'd32768;

    // Defaults for the top-level parameters
    localparam int MAX_KEPT_DEF   = 64;
    localparam int COORD_BITS_DEF = 16;

    // Stages between a memory read and the suppression flag update
    localparam int PIPE_LAT = 5;
    localparam int DRAIN_W  = 3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_AREA,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic rd_en;
        logic wr_en;
        logic finish;
        logic full;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic suppressed;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

### sv/gbs_if.sv
`default_nettype none

interface gbs_box_if;
    logic        valid;
    logic        ready;
    logic        first_of_set;
    logic [15:0] box_x;
    logic [15:0] box_y;
    logic [15:0] box_width;
    logic [15:0] box_height;

    modport source (
        output valid, first_of_set, box_x, box_y, box_width, box_height,
        input  ready
    );
    modport sink (
        input  valid, first_of_set, box_x, box_y, box_width, box_height,
        output ready
    );
endinterface

interface gbs_res_if;
    logic        valid;
    logic        ready;
    logic        keep;
    logic [15:0] box_index;
    logic        list_full;

    modport source (
        output valid, keep, box_index, list_full,
        input  ready
    );
    modport sink (
        input  valid, keep, box_index, list_full,
        output ready
    );
endinterface

`default_nettype wire

### sv/greedy_box_suppression.sv
// A box word steps through area, a scan of the K boxes kept so far (K at most MAX_KEPT),
// drain and done; no new box is taken until then. The scan pace is set by the single read port
// of the kept-box memory feeding the five-stage overlap pipeline one entry per cycle.
// The next box is taken while a finished result still waits in the output register.
// Reset (synchronous, active low) clears the kept count, set position and output valid,
// and loads the threshold with 0.5; the kept-box memory is not cleared.
`default_nettype none

module greedy_box_suppression #(
    parameter int MAX_KEPT   = gbs_pkg::MAX_KEPT_DEF,
    parameter int COORD_BITS = gbs_pkg::COORD_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    gbs_box_if.sink                            i_box,
    gbs_res_if.source                          o_res,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [gbs_pkg::THR_BITS-1:0]  i_cfg_wr_data
);

    import gbs_pkg::*;

    localparam int AW   = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CNTW = $clog2(MAX_KEPT + 1);

    t_cmd          cmd;
    t_status       status;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          in_ready;

    gbs_ctrl #(
        .MAX_KEPT (MAX_KEPT),
        .AW       (AW),
        .CNTW     (CNTW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_box.valid),
        .i_first    (i_box.first_of_set),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_rd_addr  (rd_addr),
        .o_wr_addr  (wr_addr)
    );

    gbs_dp #(
        .MAX_KEPT   (MAX_KEPT),
        .COORD_BITS (COORD_BITS),
        .AW         (AW)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_rd_addr     (rd_addr),
        .i_wr_addr     (wr_addr),
        .i_first       (i_box.first_of_set),
        .i_box_x       (i_box.box_x),
        .i_box_y       (i_box.box_y),
        .i_box_width   (i_box.box_width),
        .i_box_height  (i_box.box_height),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_out_valid   (o_res.valid),
        .i_out_ready   (o_res.ready),
        .o_keep        (o_res.keep),
        .o_box_index   (o_res.box_index),
        .o_list_full   (o_res.list_full)
    );

    assign i_box.ready = in_ready;

endmodule

`default_nettype wire

### sv/gbs_ram.sv
`default_nettype none

module gbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one word, read one word with registered output
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

### sv/gbs_ctrl.sv
`default_nettype none

module gbs_ctrl #(
    parameter int MAX_KEPT = gbs_pkg::MAX_KEPT_DEF,
    parameter int AW       = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1,
    parameter int CNTW     = $clog2(MAX_KEPT + 1)
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            i_first,
    output logic                 o_in_ready,
    input  wire gbs_pkg::t_status i_status,
    output gbs_pkg::t_cmd        o_cmd,
    output logic      [AW-1:0]   o_rd_addr,
    output logic      [AW-1:0]   o_wr_addr
);

    import gbs_pkg::*;

    localparam logic [CNTW-1:0] CNT_MAX = CNTW'(MAX_KEPT);

    t_state              r_state, n_state;
    logic [CNTW-1:0]     r_count, n_count;
    logic [AW-1:0]       r_idx, n_idx;
    logic [DRAIN_W-1:0]  r_drain, n_drain;
    logic                last_issue;

    // State and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_drain <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_drain <= n_drain;
        end
    end

    assign last_issue = (CNTW'(r_idx) + CNTW'(1)) == r_count;
    assign o_rd_addr  = r_idx;
    assign o_wr_addr  = r_count[AW-1:0];

    // Sequence one word: area, scan of kept list, drain, finish
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_drain    = r_drain;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_first) begin
                        n_count = '0;
                    end
                    n_state = S_AREA;
                end
            end
            S_AREA: begin
                n_idx = '0;
                if (r_count == '0) begin
                    n_drain = DRAIN_W'(PIPE_LAT - 1);
                    n_state = S_DRAIN;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd_en = 1'b1;
                n_idx       = r_idx + AW'(1);
                if (last_issue) begin
                    n_drain = DRAIN_W'(PIPE_LAT - 1);
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (r_drain == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_drain = r_drain - DRAIN_W'(1);
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    if (!i_status.suppressed) begin
                        if (r_count < CNT_MAX) begin
                            o_cmd.wr_en = 1'b1;
                            n_count     = r_count + CNTW'(1);
                        end else begin
                            o_cmd.full = 1'b1;
                        end
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Kept count never passes the list size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("kept count above list size");

    // Reads only touch stored entries
    a_read_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_en |-> (CNTW'(r_idx) < r_count))
        else $error("read of an entry beyond kept count");

    // A store only follows a surviving box
    a_store_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr_en |-> (o_cmd.finish && !i_status.suppressed && !o_cmd.full))
        else $error("store of a suppressed or overflow box");

    // The list counts up by at most one per word
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr_en |=> (r_count == $past(r_count) + CNTW'(1)))
        else $error("kept count did not advance after store");

endmodule

`default_nettype wire

### sv/gbs_dp.sv
`default_nettype none

module gbs_dp #(
    parameter int MAX_KEPT   = gbs_pkg::MAX_KEPT_DEF,
    parameter int COORD_BITS = gbs_pkg::COORD_BITS_DEF,
    parameter int AW         = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire gbs_pkg::t_cmd                    i_cmd,
    output gbs_pkg::t_status                      o_status,
    input  wire logic [AW-1:0]                    i_rd_addr,
    input  wire logic [AW-1:0]                    i_wr_addr,
    input  wire logic                             i_first,
    input  wire logic [gbs_pkg::BOX_BITS-1:0]     i_box_x,
    input  wire logic [gbs_pkg::BOX_BITS-1:0]     i_box_y,
    input  wire logic [gbs_pkg::BOX_BITS-1:0]     i_box_width,
    input  wire logic [gbs_pkg::BOX_BITS-1:0]     i_box_height,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [gbs_pkg::THR_BITS-1:0]     i_cfg_wr_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic                                  o_keep,
    output logic      [gbs_pkg::INDEX_BITS-1:0]   o_box_index,
    output logic                                  o_list_full
);

    import gbs_pkg::*;

    // Coordinates keep at most the field width
    localparam int CW     = (COORD_BITS < BOX_BITS) ? COORD_BITS : BOX_BITS;
    localparam int AREA_W = 2 * CW;
    localparam int UNI_W  = AREA_W + 1;
    localparam int PROD_W = UNI_W + THR_BITS;
    localparam int ENT_W  = 4 * CW + AREA_W;

    // Current box
    logic [CW-1:0]         r_x, r_y, r_w, r_h;
    logic [AREA_W-1:0]     r_area;
    logic [INDEX_BITS-1:0] r_set_pos, r_box_idx, pos;
    logic [THR_BITS-1:0]   r_thr;

    // Kept list read data and fields
    logic [ENT_W-1:0]      ram_q, ram_d;
    logic [CW-1:0]         kx, ky, kw, kh;
    logic [AREA_W-1:0]     karea;

    // Overlap terms
    logic [CW-1:0]         lo_x, lo_y;
    logic [CW:0]           ea_x, eb_x, ea_y, eb_y, hi_x, hi_y, dx, dy;
    logic [CW-1:0]         ox, oy;

    // Comparison pipeline
    logic                  r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [CW-1:0]         r_ox, r_oy;
    logic [AREA_W-1:0]     r_ka1, r_ka2, r_inter, r_inter3, r_inter4;
    logic [UNI_W-1:0]      r_uni;
    logic [PROD_W-1:0]     r_prod, lhs;
    logic                  r_sup;

    // Output register
    logic                  r_out_valid, r_keep, r_full;

    assign pos = i_first ? '0 : r_set_pos;

    // Capture the box and its place in the set
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x       <= i_box_x[CW-1:0];
            r_y       <= i_box_y[CW-1:0];
            r_w       <= i_box_width[CW-1:0];
            r_h       <= i_box_height[CW-1:0];
            r_box_idx <= pos;
        end
        r_area <= {{CW{1'b0}}, r_w} * {{CW{1'b0}}, r_h};
    end

    // Hold set position and threshold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_pos <= '0;
            r_thr     <= IOU_THR_RESET;
        end else begin
            if (i_cmd.load) begin
                r_set_pos <= pos + INDEX_BITS'(1);
            end
            if (i_cfg_wr_en) begin
                r_thr <= i_cfg_wr_data;
            end
        end
    end

    // Kept list: {area, height, width, y, x}
    assign ram_d = {r_area, r_h, r_w, r_y, r_x};

    gbs_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_KEPT),
        .AW    (AW)
    ) u_kept (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (ram_d),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (ram_q)
    );

    assign kx    = ram_q[CW-1:0];
    assign ky    = ram_q[2*CW-1:CW];
    assign kw    = ram_q[3*CW-1:2*CW];
    assign kh    = ram_q[4*CW-1:3*CW];
    assign karea = ram_q[ENT_W-1:4*CW];

    // Overlap length on each axis
    always_comb begin
        lo_x = (r_x > kx) ? r_x : kx;
        lo_y = (r_y > ky) ? r_y : ky;
        ea_x = {1'b0, r_x} + {1'b0, r_w};
        eb_x = {1'b0, kx} + {1'b0, kw};
        ea_y = {1'b0, r_y} + {1'b0, r_h};
        eb_y = {1'b0, ky} + {1'b0, kh};
        hi_x = (ea_x < eb_x) ? ea_x : eb_x;
        hi_y = (ea_y < eb_y) ? ea_y : eb_y;
        dx   = (hi_x > {1'b0, lo_x}) ? hi_x - {1'b0, lo_x} : '0;
        dy   = (hi_y > {1'b0, lo_y}) ? hi_y - {1'b0, lo_y} : '0;
        ox   = dx[CW-1:0];
        oy   = dy[CW-1:0];
    end

    assign lhs = {1'b0, r_inter4, {THR_BITS{1'b0}}};

    // Advance the comparison pipeline payload
    always_ff @(posedge i_clk) begin
        r_ox     <= ox;
        r_oy     <= oy;
        r_ka1    <= karea;
        r_inter  <= {{CW{1'b0}}, r_ox} * {{CW{1'b0}}, r_oy};
        r_ka2    <= r_ka1;
        r_uni    <= {1'b0, r_area} + {1'b0, r_ka2} - {1'b0, r_inter};
        r_inter3 <= r_inter;
        r_prod   <= {{THR_BITS{1'b0}}, r_uni} * {{UNI_W{1'b0}}, r_thr};
        r_inter4 <= r_inter3;
    end

    // Advance valid bits, flag suppression
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
            r_v5  <= 1'b0;
            r_sup <= 1'b0;
        end else begin
            r_v1 <= i_cmd.rd_en;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            if (i_cmd.load) begin
                r_sup <= 1'b0;
            end else if (r_v5 && (lhs > r_prod)) begin
                r_sup <= 1'b1;
            end
        end
    end

    // Hold the result word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_keep      <= !r_sup;
            r_full      <= i_cmd.full;
            o_box_index <= r_box_idx;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_keep              = r_keep;
    assign o_list_full         = r_full;
    assign o_status.suppressed = r_sup;
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    // A pending result word is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (!r_out_valid || i_out_ready))
        else $error("result word overwritten");

    // Suppression sticks until the next box is loaded
    a_sup_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sup && !i_cmd.load) |=> r_sup)
        else $error("suppression flag dropped mid box");

    // No comparison still in flight when a box finishes
    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> !(r_v1 || r_v2 || r_v3 || r_v4 || r_v5))
        else $error("finish with comparisons in flight");

endmodule

`default_nettype wire
